// ----- src/pbp_pkg.sv -----
package pbp_pkg;

  localparam int Frames  = 16;
  localparam int FrW     = 4;
  localparam int PinBits = 8;
  localparam logic [PinBits-1:0] PinMax = '1;

  localparam logic [2:0] ReqFetch = 3'd0;
  localparam logic [2:0] ReqUnpin = 3'd1;
  localparam logic [2:0] ReqDirty = 3'd2;
  localparam logic [2:0] ReqFlush = 3'd3;
  localparam logic [2:0] ReqFlushAll = 3'd4;

  localparam logic [3:0] StHit = 4'd0;
  localparam logic [3:0] StMiss = 4'd1;
  localparam logic [3:0] StAllPinned = 4'd2;
  localparam logic [3:0] StUnpinned = 4'd3;
  localparam logic [3:0] StBadPin = 4'd4;
  localparam logic [3:0] StFlushed = 4'd5;
  localparam logic [3:0] StClean = 4'd6;
  localparam logic [3:0] StNotRes = 4'd7;
  localparam logic [3:0] StFlushItem = 4'd8;
  localparam logic [3:0] StDone = 4'd9;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] file_id;
    logic [31:0] page_num;
    logic [3:0]  frame_sel;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [3:0]  frame_out;
    logic        load_needed;
    logic        writeback_valid;
    logic [15:0] writeback_file;
    logic [31:0] writeback_page;
    logic        last;
  } rsp_t;

  // one frame record held in the frame memory
  typedef struct packed {
    logic               valid;
    logic [15:0]        file;
    logic [31:0]        page;
    logic [PinBits-1:0] pin;
    logic               dirty;
    logic [FrW-1:0]     rank;
  } frame_t;

endpackage

// ----- src/page_buffer_pool_lru_pin.sv -----
// Page buffer pool with LRU replacement and pinning over 16 frames. Frame
// records live in one memory with a registered read; every request of codes
// 0 to 4 walks all frames through that port, one read per cycle with writes
// one frame behind. A request keeps busy high while it walks and gives its
// result in its last busy cycle; a fetch hit or miss then walks the frames a
// second time to age the ranks and keeps busy high until that walk ends.
// Flush-all gives one result per dirty frame while it walks, at no extra cost,
// then a final done. Request codes 5 to 7 are accepted and ignored: busy stays
// low and no result appears. busy is high for the whole transaction. Results
// appear for one cycle on rsp with rsp_valid and cannot be held off. Reset
// clears the memory in a pass over all 16 frames during which busy stays high.
module page_buffer_pool_lru_pin (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  pbp_pkg::req_t req,
  output logic          busy,
  output logic          rsp_valid,
  output pbp_pkg::rsp_t rsp
);

  localparam int FW = pbp_pkg::FrW;
  localparam int PB = pbp_pkg::PinBits;

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_SCAN, S_DEC, S_UPD, S_FIN} state_t;

  pbp_pkg::frame_t mem [pbp_pkg::Frames];
  pbp_pkg::frame_t rd;
  logic [FW-1:0]   free_stack [pbp_pkg::Frames];
  logic [FW:0]     free_count;

  state_t          state;
  pbp_pkg::req_t   cur;
  logic [FW:0]     cnt;       // read address counter
  logic [FW-1:0]   raddr;
  logic            rd_vld;
  logic [FW-1:0]   rd_idx;
  logic            wen;
  logic [FW-1:0]   waddr;
  pbp_pkg::frame_t wdata;

  // scan results
  logic            hit;
  logic [FW-1:0]   hit_fr;
  pbp_pkg::frame_t hit_rec;
  logic            vic;
  logic [FW-1:0]   vic_fr;
  pbp_pkg::frame_t vic_rec;
  logic            sel_ok;
  pbp_pkg::frame_t sel_rec;

  // decision
  logic [FW-1:0]   tgt;
  logic [FW-1:0]   ref_rank;
  logic            age_all;
  logic            do_age;

  assign raddr = cnt[FW-1:0];

  // memory read port
  always_ff @(posedge clk) begin
    rd <= mem[raddr];
    if (wen) mem[waddr] <= wdata;
  end

  // free stack memory
  always_ff @(posedge clk) begin
    if (state == S_CLR) free_stack[raddr] <= raddr;
  end

  always_ff @(posedge clk) begin
    wen       <= 1'b0;
    rsp_valid <= 1'b0;
    rsp       <= '0;
    if (rst) begin
      state      <= S_CLR;
      cnt        <= '0;
      rd_vld     <= 1'b0;
      free_count <= (FW+1)'(pbp_pkg::Frames);
      busy       <= 1'b1;
    end else begin
      rd_vld <= 1'b0;
      unique case (state)
        // clearing pass
        S_CLR: begin
          wen   <= 1'b1;
          waddr <= raddr;
          wdata <= '0;
          cnt   <= cnt + 1'b1;
          if (cnt == (FW+1)'(pbp_pkg::Frames - 1)) begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        S_IDLE: begin
          cnt <= '0;
          if (start) begin
            cur     <= req;
            hit     <= 1'b0;
            vic     <= 1'b0;
            sel_ok  <= 1'b0;
            if (req.req_type > pbp_pkg::ReqFlushAll) begin
              busy <= 1'b0;
            end else begin
              busy  <= 1'b1;
              state <= S_SCAN;
            end
          end
        end
        // walk all frames, one read per cycle
        S_SCAN: begin
          if (!cnt[FW]) begin
            cnt    <= cnt + 1'b1;
            rd_vld <= 1'b1;
            rd_idx <= raddr;
          end
          if (rd_vld) begin
            if (rd.valid && rd.file == cur.file_id && rd.page == cur.page_num
                && !hit) begin
              hit     <= 1'b1;
              hit_fr  <= rd_idx;
              hit_rec <= rd;
            end
            if (rd.valid && rd.pin == '0 && (!vic || rd.rank > vic_rec.rank)) begin
              vic     <= 1'b1;
              vic_fr  <= rd_idx;
              vic_rec <= rd;
            end
            if (rd_idx == cur.frame_sel) begin
              sel_ok  <= rd.valid;
              sel_rec <= rd;
            end
            // flush all: emit and clean dirty frames as they pass
            if (cur.req_type == pbp_pkg::ReqFlushAll && rd.valid && rd.dirty) begin
              rsp_valid <= 1'b1;
              rsp.status <= pbp_pkg::StFlushItem;
              rsp.frame_out <= rd_idx;
              rsp.writeback_valid <= 1'b1;
              rsp.writeback_file <= rd.file;
              rsp.writeback_page <= rd.page;
              wen   <= 1'b1;
              waddr <= rd_idx;
              wdata <= rd;
              wdata.dirty <= 1'b0;
            end
            if (rd_idx == FW'(pbp_pkg::Frames - 1)) state <= S_DEC;
          end
        end
        // decide the request and write the target frame
        S_DEC: begin
          state   <= S_FIN;
          do_age  <= 1'b0;
          rsp_valid <= 1'b1;
          rsp.last  <= 1'b1;
          unique case (cur.req_type)
            pbp_pkg::ReqFetch: begin
              if (hit) begin
                rsp.frame_out <= hit_fr;
                rsp.status <= (hit_rec.pin == pbp_pkg::PinMax) ?
                              pbp_pkg::StBadPin : pbp_pkg::StHit;
                wen   <= 1'b1;
                waddr <= hit_fr;
                wdata <= hit_rec;
                wdata.rank <= '0;
                if (hit_rec.pin != pbp_pkg::PinMax) wdata.pin <= hit_rec.pin + 1'b1;
                tgt <= hit_fr; ref_rank <= hit_rec.rank; age_all <= 1'b0;
                do_age <= 1'b1;
              end else if (free_count != '0 || vic) begin
                if (free_count != '0) begin
                  tgt        <= free_stack[FW'(free_count - 1'b1)];
                  waddr      <= free_stack[FW'(free_count - 1'b1)];
                  rsp.frame_out <= free_stack[FW'(free_count - 1'b1)];
                  free_count <= free_count - 1'b1;
                  age_all    <= 1'b1;
                end else begin
                  tgt      <= vic_fr;
                  waddr    <= vic_fr;
                  rsp.frame_out <= vic_fr;
                  ref_rank <= vic_rec.rank;
                  age_all  <= 1'b0;
                  rsp.writeback_valid <= vic_rec.dirty;
                  rsp.writeback_file  <= vic_rec.dirty ? vic_rec.file : '0;
                  rsp.writeback_page  <= vic_rec.dirty ? vic_rec.page : '0;
                end
                do_age <= 1'b1;
                rsp.status <= pbp_pkg::StMiss;
                rsp.load_needed <= 1'b1;
                wen <= 1'b1;
                wdata <= '{valid: 1'b1, file: cur.file_id, page: cur.page_num,
                           pin: PB'(1), dirty: 1'b0, rank: '0};
              end else begin
                rsp.status <= pbp_pkg::StAllPinned;
              end
            end
            pbp_pkg::ReqUnpin, pbp_pkg::ReqDirty: begin
              rsp.frame_out <= cur.frame_sel;
              waddr <= cur.frame_sel;
              wdata <= sel_rec;
              if (!sel_ok) begin
                rsp.status <= pbp_pkg::StNotRes;
              end else if (cur.req_type == pbp_pkg::ReqDirty) begin
                rsp.status <= pbp_pkg::StHit;
                wen <= 1'b1;
                wdata.dirty <= 1'b1;
              end else if (sel_rec.pin == '0) begin
                rsp.status <= pbp_pkg::StBadPin;
              end else begin
                rsp.status <= pbp_pkg::StUnpinned;
                wen <= 1'b1;
                wdata.pin <= sel_rec.pin - 1'b1;
              end
            end
            pbp_pkg::ReqFlush: begin
              waddr <= hit_fr;
              wdata <= hit_rec;
              wdata.dirty <= 1'b0;
              if (!hit) begin
                rsp.status <= pbp_pkg::StNotRes;
              end else if (hit_rec.dirty) begin
                rsp.status <= pbp_pkg::StFlushed;
                rsp.frame_out <= hit_fr;
                rsp.writeback_valid <= 1'b1;
                rsp.writeback_file <= hit_rec.file;
                rsp.writeback_page <= hit_rec.page;
                wen <= 1'b1;
              end else begin
                rsp.status <= pbp_pkg::StClean;
                rsp.frame_out <= hit_fr;
              end
            end
            default: begin
              rsp.status <= pbp_pkg::StDone;
            end
          endcase
        end
        // second pass: age ranks after a move to front
        S_FIN: begin
          cnt   <= '0;
          state <= do_age ? S_UPD : S_IDLE;
          busy  <= do_age;
        end
        S_UPD: begin
          if (!cnt[FW]) begin
            cnt    <= cnt + 1'b1;
            rd_vld <= 1'b1;
            rd_idx <= raddr;
          end
          if (rd_vld) begin
            if (rd.valid && rd_idx != tgt && (age_all || rd.rank < ref_rank)) begin
              wen   <= 1'b1;
              waddr <= rd_idx;
              wdata <= rd;
              wdata.rank <= rd.rank + 1'b1;
            end
            if (rd_idx == FW'(pbp_pkg::Frames - 1)) begin
              state <= S_IDLE;
              busy  <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // no result while idle without a request in flight
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !$past(state == S_DEC)) |-> !rsp_valid)
    else $error("result while idle");
  // flush items never close the transaction
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == pbp_pkg::StFlushItem) |-> !rsp.last)
    else $error("flush item marked last");
  a_free_range: assert property (@(posedge clk) disable iff (rst)
    free_count <= (FW+1)'(pbp_pkg::Frames))
    else $error("free count out of range");

endmodule
